// ===== hw/rtl/fsse_pkg.sv =====
// Shared types and constants of the frame slack sleep estimator.
`timescale 1ns / 1ps

package fsse_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_SLEEP = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] REG_EXPERIMENTAL = 2'd0;
  localparam logic [1:0] REG_SCALE        = 2'd1;
  localparam logic [1:0] REG_OFFSET       = 2'd2;

  localparam logic        RESET_EXPERIMENTAL = 1'b0;
  localparam logic [15:0] RESET_SCALE        = 16'd58982;
  localparam logic [23:0] RESET_OFFSET       = 24'hFFFC18;

  localparam int FRAME_W      = 32;
  localparam int MOD_BITS     = 4;
  localparam int MOD_STEPS    = FRAME_W / MOD_BITS;
  localparam int MOD_CNT_W    = $clog2(MOD_STEPS);
  localparam int EXTRA_W      = 22;

  localparam logic [22:0] RECIP_1000 = 23'd4294967;
  localparam logic [25:0] RECIP_100  = 26'd42949672;
  localparam logic [31:0] US_PER_MS  = 32'd1000;
  localparam logic [31:0] PERCENT    = 32'd100;
  localparam logic [31:0] CEIL_BIAS  = 32'd99;
  localparam logic [30:0] TARGET_MAX = 31'h7FFFFFFF;

  typedef struct packed {
    logic               exp_en;
    logic [15:0]        scale;
    logic signed [23:0] offset;
  } fsse_cfg_t;

  typedef struct packed {
    logic load;
    logic frame_step;
    logic scan;
    logic mul;
    logic tgt;
    logic diff;
    logic divm;
    logic divr;
    logic divc;
    logic crm;
    logic crr;
    logic crc;
    logic mod_step;
    logic slot_read;
    logic slot_write;
    logic out_load;
  } fsse_cmd_t;

  typedef struct packed {
    logic window_ok;
    logic mod_last;
    logic scan_done;
    logic out_busy;
  } fsse_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_MUL,
    ST_TGT,
    ST_DIFF,
    ST_DIVM,
    ST_DIVR,
    ST_DIVC,
    ST_CRM,
    ST_CRR,
    ST_CRC,
    ST_MOD,
    ST_SRD,
    ST_WR,
    ST_DONE
  } fsse_state_t;

endpackage

// ===== hw/rtl/fsse_item_if.sv =====
// Input channel carrying one estimator operation per transfer.
`timescale 1ns / 1ps

interface fsse_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [23:0]        slept_us;
  logic [31:0]        frame_index;
  logic signed [24:0] duration_us;

  modport source (output valid, output operation, output slept_us, output frame_index,
                  output duration_us, input ready);
  modport sink (input valid, input operation, input slept_us, input frame_index,
                input duration_us, output ready);
endinterface

// ===== hw/rtl/fsse_result_if.sv =====
// Output channel carrying one estimator result per transfer.
`timescale 1ns / 1ps

interface fsse_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_number;
  logic [21:0] extra_sleep_ms;
  logic [31:0] window_min_us;

  modport source (output valid, output frame_number, output extra_sleep_ms,
                  output window_min_us, input ready);
  modport sink (input valid, input frame_number, input extra_sleep_ms,
                input window_min_us, output ready);
endinterface

// ===== hw/rtl/fsse_datapath.sv =====
// Datapath of the estimator: slack ring, frame counter, arithmetic and result register.
`timescale 1ns / 1ps

module fsse_datapath #(
  parameter int HISTORY_DEPTH     = 8,
  parameter int INCOMPLETE_FRAMES = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  fsse_pkg::fsse_cmd_t cmd,
  input  fsse_pkg::fsse_cfg_t cfg,
  output fsse_pkg::fsse_stat_t stat,
  input  logic [23:0]         slept_us,
  input  logic [31:0]         frame_index,
  input  logic signed [24:0]  duration_us,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [31:0]         frame_number,
  output logic [21:0]         extra_sleep_ms,
  output logic [31:0]         window_min_us
);
  import fsse_pkg::*;

  localparam int SW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_DEPTH - 1);
  localparam logic [SW:0]   DEPTH_R   = (SW+1)'(HISTORY_DEPTH);
  localparam logic [SW+1:0] DEPTH_S   = (SW+2)'(HISTORY_DEPTH);
  localparam logic [FW-1:0] DEPTH_F   = FW'(HISTORY_DEPTH);
  localparam logic [FW-1:0] MIN_FILL  = FW'(INCOMPLETE_FRAMES);
  localparam logic [FW-1:0] WIN_SKIP  = FW'(INCOMPLETE_FRAMES + 1);
  localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);

  logic [31:0]          mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] mem_valid;
  logic [31:0]          rd_data;
  logic                 rd_valid;
  logic [31:0]          rd_word;

  logic [31:0]          counter;
  logic [SW-1:0]        cslot;
  logic [FW-1:0]        fill;
  logic [31:0]          counter_next;
  logic [SW-1:0]        cslot_next;
  logic [FW-1:0]        fill_next;

  logic [31:0]          slept;
  logic [31:0]          frame_sh;
  logic [SW-1:0]        rem;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [SW:0]          mod_acc;
  logic [31:0]          addend;
  logic [SW-1:0]        wr_slot;

  logic [SW-1:0]        scan_addr;
  logic [FW-1:0]        scan_left;
  logic                 scan_pend;
  logic                 scan_first;
  logic [SW+1:0]        start_sum;
  logic [SW+1:0]        start_red;
  logic [FW-1:0]        scan_n;

  logic [31:0]          min_r;
  logic [47:0]          prod_m;
  logic signed [49:0]   tsum;
  logic [30:0]          tgt;
  logic [32:0]          xd;
  logic [30:0]          xr;
  logic [53:0]          prod_d;
  logic [21:0]          q0_d;
  logic [10:0]          r0_d;
  logic [31:0]          rd_full;
  logic [21:0]          q_d;
  logic [10:0]          r_d;
  logic [21:0]          extra_r;
  logic [31:0]          y_c;
  logic [57:0]          prod_c;
  logic [25:0]          q0_c;
  logic [7:0]           r0_c;
  logic [31:0]          rc_full;
  logic [25:0]          q_c;

  logic                 re;
  logic [SW-1:0]        raddr;
  logic                 we;
  logic [SW-1:0]        waddr;
  logic [31:0]          wdata;

  assign rd_word = rd_valid ? rd_data : 32'd0;

  always_comb begin
    counter_next = counter + 32'd1;
    if (counter_next == 32'd0) begin
      cslot_next = '0;
      fill_next  = '0;
    end else begin
      cslot_next = (cslot == LAST_SLOT) ? '0 : cslot + SW'(1);
      fill_next  = (fill == DEPTH_F) ? fill : fill + FW'(1);
    end
  end

  always_comb begin
    start_sum = (SW+2)'(cslot) + DEPTH_S - (SW+2)'(fill) + (SW+2)'(1);
    start_red = (start_sum >= DEPTH_S) ? start_sum - DEPTH_S : start_sum;
    scan_n    = (fill > WIN_SKIP) ? fill - WIN_SKIP : FW'(1);
  end

  always_comb begin
    mod_acc = {1'b0, rem};
    for (int i = 0; i < MOD_BITS; i++) begin
      mod_acc = {mod_acc[SW-1:0], frame_sh[FRAME_W-1-i]};
      if (mod_acc >= DEPTH_R) begin
        mod_acc = mod_acc - DEPTH_R;
      end
    end
  end

  always_comb begin
    tsum = $signed({2'b00, prod_m}) + $signed({{10{cfg.offset[23]}}, cfg.offset, 16'd0});
    xd   = {2'b00, tgt} - {1'b0, slept};
    rd_full = {1'b0, xr} - (32'(prod_d[53:32]) * US_PER_MS);
    if (r0_d >= 11'(US_PER_MS)) begin
      q_d = q0_d + 22'd1;
      r_d = r0_d - 11'(US_PER_MS);
    end else begin
      q_d = q0_d;
      r_d = r0_d;
    end
    rc_full = y_c - (32'(prod_c[57:32]) * PERCENT);
    q_c = (r0_c >= 8'(PERCENT)) ? q0_c + 26'd1 : q0_c;
  end

  always_comb begin
    re    = (cmd.scan && scan_left != '0) || cmd.crm || cmd.slot_read;
    raddr = cmd.crm ? cslot : (cmd.slot_read ? rem : scan_addr);
    we    = cmd.frame_step || cmd.slot_write;
    waddr = cmd.frame_step ? cslot_next : wr_slot;
    wdata = cmd.frame_step ? 32'd0 : rd_word + addend;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (we) begin
        mem_valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= mem_valid[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter    <= '0;
      cslot      <= '0;
      fill       <= '0;
      scan_left  <= '0;
      scan_pend  <= 1'b0;
      scan_first <= 1'b0;
      mod_cnt    <= '0;
    end else begin
      if (cmd.frame_step) begin
        counter <= counter_next;
        cslot   <= cslot_next;
        fill    <= fill_next;
      end
      if (cmd.load) begin
        scan_addr  <= start_red[SW-1:0];
        scan_left  <= scan_n;
        scan_pend  <= 1'b0;
        scan_first <= 1'b1;
        mod_cnt    <= '0;
      end
      if (cmd.scan) begin
        if (scan_pend) begin
          scan_first <= 1'b0;
        end
        if (scan_left != '0) begin
          scan_addr <= (scan_addr == LAST_SLOT) ? '0 : scan_addr + SW'(1);
          scan_left <= scan_left - FW'(1);
          scan_pend <= 1'b1;
        end else begin
          scan_pend <= 1'b0;
        end
      end
      if (cmd.mod_step) begin
        mod_cnt <= mod_cnt + MOD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slept    <= {8'd0, slept_us};
      frame_sh <= frame_index;
      rem      <= '0;
      addend   <= {{7{duration_us[24]}}, duration_us};
      min_r    <= '0;
      extra_r  <= '0;
    end
    if (cmd.scan && scan_pend && (scan_first || rd_word < min_r)) begin
      min_r <= rd_word;
    end
    if (cmd.mod_step) begin
      rem      <= mod_acc[SW-1:0];
      frame_sh <= frame_sh << MOD_BITS;
    end
    if (cmd.mul) begin
      prod_m <= {32'd0, cfg.scale} * {16'd0, min_r};
    end
    if (cmd.tgt) begin
      if (tsum[49]) begin
        tgt <= '0;
      end else if (tsum[48:47] != 2'b00) begin
        tgt <= TARGET_MAX;
      end else begin
        tgt <= tsum[46:16];
      end
    end
    if (cmd.diff) begin
      xr <= (!xd[32] && xd != 33'd0) ? xd[30:0] : 31'd0;
    end
    if (cmd.divm) begin
      prod_d <= {23'd0, xr} * {31'd0, RECIP_1000};
    end
    if (cmd.divr) begin
      q0_d <= prod_d[53:32];
      r0_d <= rd_full[10:0];
    end
    if (cmd.divc) begin
      extra_r <= q_d;
      if (q_d != 22'd0) begin
        slept <= {1'b0, tgt} - {21'd0, r_d};
      end
    end
    if (cmd.crm) begin
      y_c     <= slept + CEIL_BIAS;
      prod_c  <= {26'd0, slept + CEIL_BIAS} * {32'd0, RECIP_100};
      wr_slot <= cslot;
    end
    if (cmd.slot_read) begin
      wr_slot <= rem;
    end
    if (cmd.crr) begin
      q0_c <= prod_c[57:32];
      r0_c <= rc_full[7:0];
    end
    if (cmd.crc) begin
      addend <= slept - {6'd0, q_c};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frame_number   <= counter;
      extra_sleep_ms <= extra_r;
      window_min_us  <= min_r;
    end
  end

  always_comb begin
    stat.window_ok = cfg.exp_en && (fill >= MIN_FILL);
    stat.mod_last  = (mod_cnt == MOD_LAST);
    stat.scan_done = (scan_left == '0) && !scan_pend;
    stat.out_busy  = result_valid && !result_ready;
  end

endmodule

// ===== hw/rtl/fsse_control.sv =====
// Sequencing state machine of the estimator.
`timescale 1ns / 1ps

module fsse_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic [1:0]           item_op,
  output logic                 item_ready,
  input  fsse_pkg::fsse_stat_t stat,
  output fsse_pkg::fsse_cmd_t  cmd
);
  import fsse_pkg::*;

  fsse_state_t state;
  fsse_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          unique case (item_op)
            OP_START: state_next = ST_START;
            OP_SLEEP: state_next = stat.window_ok ? ST_SCAN : ST_CRM;
            OP_ADD:   state_next = ST_MOD;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_START: begin
        cmd.frame_step = 1'b1;
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_TGT;
      end
      ST_TGT: begin
        cmd.tgt = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff = 1'b1;
        state_next = ST_DIVM;
      end
      ST_DIVM: begin
        cmd.divm = 1'b1;
        state_next = ST_DIVR;
      end
      ST_DIVR: begin
        cmd.divr = 1'b1;
        state_next = ST_DIVC;
      end
      ST_DIVC: begin
        cmd.divc = 1'b1;
        state_next = ST_CRM;
      end
      ST_CRM: begin
        cmd.crm = 1'b1;
        state_next = ST_CRR;
      end
      ST_CRR: begin
        cmd.crr = 1'b1;
        state_next = ST_CRC;
      end
      ST_CRC: begin
        cmd.crc = 1'b1;
        state_next = ST_WR;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = ST_SRD;
        end
      end
      ST_SRD: begin
        cmd.slot_read = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.slot_write = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/frame_slack_sleep_estimator.sv =====
// Top level of the frame slack sleep estimator: register port, controller and datapath.
//
//   channel   role    transfer moves
//   items     sink    operation, slept_us, frame_index, duration_us
//   results   source  frame_number, extra_sleep_ms, window_min_us
//   apb       slave   experimental_enable, sleep_scale_q16, sleep_offset_us
//
// One item is worked on at a time. Start frame, add slack and a sleep decision each step
// through their own states; with the window, a sleep decision first scans the window
// slots one by one through the single read port of the slack ring.
// Reset clears the per-slot valid bits at once, so no clearing pass follows it.
// A result held in the output register stalls the next item in its last cycle until
// that result's transfer completes.
`timescale 1ns / 1ps

module frame_slack_sleep_estimator #(
  parameter int HISTORY_DEPTH     = 8,
  parameter int INCOMPLETE_FRAMES = 2
) (
  input  logic        clk,
  input  logic        rst,
  fsse_item_if.sink   items,
  fsse_result_if.source results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fsse_pkg::*;

  fsse_cfg_t  cfg;
  fsse_cmd_t  cmd;
  fsse_stat_t stat;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exp_en <= RESET_EXPERIMENTAL;
      cfg.scale  <= RESET_SCALE;
      cfg.offset <= RESET_OFFSET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        REG_EXPERIMENTAL: cfg.exp_en <= pwdata[0];
        REG_SCALE:        cfg.scale  <= pwdata[15:0];
        REG_OFFSET:       cfg.offset <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_EXPERIMENTAL: prdata = {31'd0, cfg.exp_en};
      REG_SCALE:        prdata = {16'd0, cfg.scale};
      REG_OFFSET:       prdata = {{8{cfg.offset[23]}}, cfg.offset};
      default:          prdata = 32'd0;
    endcase
  end

  fsse_control u_control (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_op    (items.operation),
    .item_ready (items.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  fsse_datapath #(
    .HISTORY_DEPTH     (HISTORY_DEPTH),
    .INCOMPLETE_FRAMES (INCOMPLETE_FRAMES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .stat           (stat),
    .slept_us       (items.slept_us),
    .frame_index    (items.frame_index),
    .duration_us    (items.duration_us),
    .result_valid   (results.valid),
    .result_ready   (results.ready),
    .frame_number   (results.frame_number),
    .extra_sleep_ms (results.extra_sleep_ms),
    .window_min_us  (results.window_min_us)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready |=> !items.ready)
    else $error("input accepted while an item is still in progress");

  a_extra_bound: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.extra_sleep_ms <= 22'd2147483)
    else $error("extra sleep beyond the saturated target");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(cmd.out_load))
    else $error("result raised without a load from the controller");

endmodule
